/* rtl/core/tab_pkg.sv */
// ----------------------------------------------------------------------------
// tab_pkg
// shared types, codes and constants of the typed arena bump allocator
// ----------------------------------------------------------------------------
`default_nettype none

package tab_pkg;

    localparam int DEF_MAX_ARENAS = 16;
    localparam int DEF_SIZE_BITS  = 24;

    localparam int BYTES_W   = 24;
    localparam int ALIGN_W   = 17;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int USZ_W     = 17;
    localparam int UAL_W     = 9;
    localparam int REM_W     = 17;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    localparam logic OP_ACQUIRE     = 1'b0;
    localparam logic OP_FRAME_RESET = 1'b1;

    localparam logic [1:0] KIND_VERTEX  = 2'd0;
    localparam logic [1:0] KIND_INDEX   = 2'd1;
    localparam logic [1:0] KIND_UNIFORM = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [1:0] STS_GRANTED    = 2'd0;
    localparam logic [1:0] STS_TOO_LARGE  = 2'd1;
    localparam logic [1:0] STS_TABLE_FULL = 2'd2;
    localparam logic [1:0] STS_RESET_DONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VTX_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNI_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNI_ALIGN = 2'd3;

    localparam logic [BYTES_W-1:0] RST_VTX_SIZE  = 24'd262144;
    localparam logic [BYTES_W-1:0] RST_IDX_SIZE  = 24'd65536;
    localparam logic [USZ_W-1:0]   RST_UNI_SIZE  = 17'd65536;
    localparam logic [UAL_W-1:0]   RST_UNI_ALIGN = 9'd256;

    localparam logic [USZ_W-1:0]   UNIFORM_CLAMP     = 17'd65536;
    localparam logic [ALIGN_W-1:0] VERTEX_BASE_ALIGN = 17'd4;
    localparam logic [ALIGN_W-1:0] INDEX_BASE_ALIGN  = 17'd2;

    localparam int RST_ARENAS = 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN_WAIT,
        S_ALIGN_SET,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_USED_WAIT,
        S_PAD,
        S_FIT,
        S_OPEN,
        S_FRAME,
        S_REJECT,
        S_FULL
    } t_state;

    typedef enum logic [2:0] {
        RES_GRANT,
        RES_OPEN,
        RES_TOO_LARGE,
        RES_FULL,
        RES_RESET
    } t_res;

    typedef struct packed {
        logic load_req;
        logic size_ld;
        logic mod_go_align;
        logic align_set;
        logic scan_clr;
        logic scan_rd;
        logic scan_inc;
        logic mod_go_used;
        logic pad_ld;
        logic wr_bump;
        logic wr_open;
        logic frame_clr;
        logic res_ld;
        t_res res_sel;
    } t_cmd;

    typedef struct packed {
        logic is_frame;
        logic bad_kind;
        logic oversize;
        logic mod_done;
        logic scan_end;
        logic match;
        logic fit;
        logic table_full;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/typed_arena_bump_allocator.sv */
// ----------------------------------------------------------------------------
// typed_arena_bump_allocator
// aligned range allocator over a table of vertex, index and uniform arenas
// ----------------------------------------------------------------------------
// One result per input transfer, one item in flight at a time. Let D be the
// larger of SIZE_BITS and 17 (24 by default): the remainder unit divides a
// D-bit dividend, one dividend bit per cycle. A taken transfer is checked and
// its alignment resolved; then the arenas are read in turn, first fit: one of
// the requested kind has its padding and room worked out and is granted if
// the range fits, one of another kind is passed over. Running past the last
// arena opens a new one or reports a full table. Frame resets and rejected
// requests go straight to their result. A finished result waits in the output
// register while the next transfer is accepted; a result that finds the output
// register still occupied holds the sequencer until it drains.
`default_nettype none

module typed_arena_bump_allocator #(
    parameter int MAX_ARENAS = tab_pkg::DEF_MAX_ARENAS,
    parameter int SIZE_BITS  = tab_pkg::DEF_SIZE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tab_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tab_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // request_bytes[23:0], request_align[40:24], zero fill
    input  wire logic [tab_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode[0], arena_kind_req[2:1]
    input  wire logic [tab_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // arena_slot[3:0], grant_offset[27:4], grant_bytes[51:28], zero fill
    output logic [tab_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // opened_arena[0], status[2:1]
    output logic [tab_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    tab_pkg::t_cmd                 cmd;
    tab_pkg::t_sts                 sts;
    logic [tab_pkg::SLOT_W-1:0]    res_slot;
    logic [tab_pkg::BYTES_W-1:0]   res_offset;
    logic [tab_pkg::BYTES_W-1:0]   res_bytes;
    logic                          res_opened;
    logic [1:0]                    res_status;

    tab_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    tab_datapath #(
        .MAX_ARENAS (MAX_ARENAS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (s_axis_tuser[0]),
        .i_kind     (s_axis_tuser[2:1]),
        .i_bytes    (s_axis_tdata[23:0]),
        .i_align    (s_axis_tdata[40:24]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_slot     (res_slot),
        .o_offset   (res_offset),
        .o_bytes    (res_bytes),
        .o_opened   (res_opened),
        .o_status   (res_status)
    );

    assign m_axis_tdata = {4'b0, res_bytes, res_offset, res_slot};
    assign m_axis_tuser = {res_status, res_opened};

endmodule

`default_nettype wire

/* rtl/core/tab_mod_unit.sv */
// ----------------------------------------------------------------------------
// tab_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tab_mod_unit #(
    parameter int DW = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [DW-1:0]              i_dividend,
    input  wire logic [tab_pkg::REM_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [tab_pkg::REM_W-1:0]       o_rem
);

    localparam int CTW = $clog2(DW + 1);

    logic [CTW-1:0]              r_cnt;
    logic [DW-1:0]               r_dvd;
    logic [tab_pkg::REM_W-1:0]   r_dvs;
    logic [tab_pkg::REM_W-1:0]   r_rem;
    logic [tab_pkg::REM_W:0]     trial;
    logic [tab_pkg::REM_W:0]     diff;
    logic                        ge;

    assign trial = {r_rem, r_dvd[DW-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CTW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[tab_pkg::REM_W-1:0] : trial[tab_pkg::REM_W-1:0];
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/core/tab_datapath.sv */
// ----------------------------------------------------------------------------
// tab_datapath
// config registers, arena table memory, fit arithmetic and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tab_datapath #(
    parameter int MAX_ARENAS = tab_pkg::DEF_MAX_ARENAS,
    parameter int SIZE_BITS  = tab_pkg::DEF_SIZE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tab_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tab_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_opcode,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [tab_pkg::BYTES_W-1:0]   i_bytes,
    input  wire logic [tab_pkg::ALIGN_W-1:0]   i_align,
    input  wire tab_pkg::t_cmd                 i_cmd,
    output tab_pkg::t_sts                      o_sts,
    output logic [tab_pkg::SLOT_W-1:0]         o_slot,
    output logic [tab_pkg::BYTES_W-1:0]        o_offset,
    output logic [tab_pkg::BYTES_W-1:0]        o_bytes,
    output logic                               o_opened,
    output logic [1:0]                         o_status
);

    localparam int SLW = $clog2(MAX_ARENAS);
    localparam int CNW = $clog2(MAX_ARENAS + 1);
    localparam int DW  = (SIZE_BITS > tab_pkg::ALIGN_W) ? SIZE_BITS : tab_pkg::ALIGN_W;
    localparam int TW  = SIZE_BITS + 2;
    localparam logic [33:0] SIZE_LIM = (34'd1 << SIZE_BITS) - 34'd1;

    // configuration
    logic [tab_pkg::BYTES_W-1:0] r_vtx_size;
    logic [tab_pkg::BYTES_W-1:0] r_idx_size;
    logic [tab_pkg::USZ_W-1:0]   r_uni_size;
    logic [tab_pkg::UAL_W-1:0]   r_uni_align;

    // latched request
    logic                        r_opcode;
    logic [1:0]                  r_kind;
    logic [tab_pkg::BYTES_W-1:0] r_bytes;
    logic [tab_pkg::ALIGN_W-1:0] r_req_align;

    logic [SIZE_BITS-1:0]        r_size;
    logic [tab_pkg::ALIGN_W-1:0] r_base;
    logic [tab_pkg::ALIGN_W-1:0] r_align;
    logic [tab_pkg::ALIGN_W-1:0] r_pad;
    logic [33:0]                 r_room;

    // arena table
    logic [TW-1:0]               r_mem [MAX_ARENAS];
    logic [TW-1:0]               r_rd_word;
    logic                        r_rd_vld;
    logic                        r_rd_fix;
    logic [1:0]                  r_rd_fixtag;
    logic [MAX_ARENAS-1:0]       r_used_vld;
    logic [CNW-1:0]              r_count;
    logic [CNW-1:0]              r_scan;

    logic [tab_pkg::BYTES_W-1:0] size_raw;
    logic [33:0]                 size_eff;
    logic [tab_pkg::ALIGN_W-1:0] base;
    logic [1:0]                  rd_tag;
    logic [SIZE_BITS-1:0]        rd_used;
    logic                        mod_start;
    logic [DW-1:0]               mod_dvd;
    logic [tab_pkg::REM_W-1:0]   mod_dvs;
    logic                        mod_done;
    logic [tab_pkg::REM_W-1:0]   mod_rem;
    logic [33:0]                 off_sum;
    logic [33:0]                 end_sum;
    logic                        table_full;
    logic                        wr_en;
    logic [SLW-1:0]              wr_addr;
    logic [TW-1:0]               wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_size  <= tab_pkg::RST_VTX_SIZE;
            r_idx_size  <= tab_pkg::RST_IDX_SIZE;
            r_uni_size  <= tab_pkg::RST_UNI_SIZE;
            r_uni_align <= tab_pkg::RST_UNI_ALIGN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tab_pkg::CFG_VTX_SIZE:  r_vtx_size  <= i_cfg_data;
                tab_pkg::CFG_IDX_SIZE:  r_idx_size  <= i_cfg_data;
                tab_pkg::CFG_UNI_SIZE:  r_uni_size  <= i_cfg_data[tab_pkg::USZ_W-1:0];
                tab_pkg::CFG_UNI_ALIGN: r_uni_align <= i_cfg_data[tab_pkg::UAL_W-1:0];
                default: ;
            endcase
        end
    end

    // effective size and base alignment of the requested kind
    always_comb begin
        case (r_kind)
            tab_pkg::KIND_VERTEX: begin
                size_raw = r_vtx_size;
                base     = tab_pkg::VERTEX_BASE_ALIGN;
            end
            tab_pkg::KIND_INDEX: begin
                size_raw = r_idx_size;
                base     = tab_pkg::INDEX_BASE_ALIGN;
            end
            default: begin
                size_raw = (r_uni_size > tab_pkg::UNIFORM_CLAMP) ?
                           tab_pkg::BYTES_W'(tab_pkg::UNIFORM_CLAMP) :
                           tab_pkg::BYTES_W'(r_uni_size);
                base     = (r_uni_align == '0) ? tab_pkg::ALIGN_W'(1) :
                           tab_pkg::ALIGN_W'(r_uni_align);
            end
        endcase
        size_eff = (34'(size_raw) > SIZE_LIM) ? SIZE_LIM : 34'(size_raw);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_opcode    <= i_opcode;
            r_kind      <= i_kind;
            r_bytes     <= i_bytes;
            r_req_align <= i_align;
        end
        if (i_cmd.size_ld) begin
            r_size <= size_eff[SIZE_BITS-1:0];
            r_base <= base;
        end
        if (i_cmd.align_set) begin
            r_align <= (r_req_align == '0 || mod_rem != '0) ? r_base : r_req_align;
        end
        if (i_cmd.pad_ld) begin
            r_pad  <= (mod_rem == '0) ? '0 : r_align - mod_rem;
            r_room <= 34'(r_size) - 34'(rd_used);
        end
    end

    assign mod_start = i_cmd.mod_go_align | i_cmd.mod_go_used;
    assign mod_dvd   = i_cmd.mod_go_used ? DW'(rd_used) : DW'(r_req_align);
    assign mod_dvs   = i_cmd.mod_go_used ? r_align : base;

    tab_mod_unit #(
        .DW (DW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (mod_dvs),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // slots below the reset count keep their fixed tags
    assign rd_tag  = r_rd_fix ? r_rd_fixtag : r_rd_word[TW-1:SIZE_BITS];
    assign rd_used = r_rd_vld ? r_rd_word[SIZE_BITS-1:0] : '0;
    assign off_sum = 34'(rd_used) + 34'(r_pad);
    assign end_sum = off_sum + 34'(r_bytes);

    assign table_full = (r_count >= CNW'(MAX_ARENAS));
    assign wr_en      = i_cmd.wr_bump | (i_cmd.wr_open & ~table_full);
    assign wr_addr    = i_cmd.wr_open ? r_count[SLW-1:0] : r_scan[SLW-1:0];
    assign wr_data    = i_cmd.wr_open ? {r_kind, SIZE_BITS'(r_bytes)} :
                                        {rd_tag, end_sum[SIZE_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.scan_rd) begin
            r_rd_word   <= r_mem[r_scan[SLW-1:0]];
            r_rd_vld    <= r_used_vld[r_scan[SLW-1:0]];
            r_rd_fix    <= (r_scan < CNW'(tab_pkg::RST_ARENAS));
            r_rd_fixtag <= r_scan[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_vld <= '0;
            r_count    <= CNW'(tab_pkg::RST_ARENAS);
            r_scan     <= '0;
        end else begin
            if (i_cmd.frame_clr) begin
                r_used_vld <= '0;
            end else if (wr_en) begin
                r_used_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.wr_open && !table_full) begin
                r_count <= r_count + CNW'(1);
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + CNW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            case (i_cmd.res_sel)
                tab_pkg::RES_GRANT: begin
                    o_slot   <= tab_pkg::SLOT_W'(r_scan);
                    o_offset <= off_sum[tab_pkg::BYTES_W-1:0];
                    o_bytes  <= r_bytes;
                    o_opened <= 1'b0;
                    o_status <= tab_pkg::STS_GRANTED;
                end
                tab_pkg::RES_OPEN: begin
                    o_slot   <= tab_pkg::SLOT_W'(r_count);
                    o_offset <= '0;
                    o_bytes  <= r_bytes;
                    o_opened <= 1'b1;
                    o_status <= tab_pkg::STS_GRANTED;
                end
                tab_pkg::RES_FULL: begin
                    o_slot   <= '0;
                    o_offset <= '0;
                    o_bytes  <= '0;
                    o_opened <= 1'b0;
                    o_status <= tab_pkg::STS_TABLE_FULL;
                end
                tab_pkg::RES_RESET: begin
                    o_slot   <= '0;
                    o_offset <= '0;
                    o_bytes  <= '0;
                    o_opened <= 1'b0;
                    o_status <= tab_pkg::STS_RESET_DONE;
                end
                default: begin
                    o_slot   <= '0;
                    o_offset <= '0;
                    o_bytes  <= '0;
                    o_opened <= 1'b0;
                    o_status <= tab_pkg::STS_TOO_LARGE;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.is_frame   = (r_opcode == tab_pkg::OP_FRAME_RESET);
        o_sts.bad_kind   = (r_kind == tab_pkg::KIND_NONE);
        o_sts.oversize   = (34'(r_bytes) > size_eff);
        o_sts.mod_done   = mod_done;
        o_sts.scan_end   = (r_scan >= r_count);
        o_sts.match      = (rd_tag == r_kind) && (rd_used <= r_size);
        o_sts.fit        = (r_room >= 34'(r_bytes) + 34'(r_pad));
        o_sts.table_full = table_full;
    end

endmodule

`default_nettype wire

/* rtl/core/tab_ctrl.sv */
// ----------------------------------------------------------------------------
// tab_ctrl
// sequencer of the allocator: request checks, arena scan and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module tab_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    input  wire logic          i_m_ready,
    input  wire tab_pkg::t_sts i_sts,
    output logic               o_s_ready,
    output logic               o_m_valid,
    output tab_pkg::t_cmd      o_cmd
);

    tab_pkg::t_state r_state;
    tab_pkg::t_state n_state;
    logic            r_out_vld;
    logic            out_free;

    assign out_free = ~r_out_vld | i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tab_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tab_pkg::S_IDLE: begin
                if (i_s_valid) n_state = tab_pkg::S_CHECK;
            end
            tab_pkg::S_CHECK: begin
                if (i_sts.is_frame) begin
                    n_state = tab_pkg::S_FRAME;
                end else if (i_sts.bad_kind || i_sts.oversize) begin
                    n_state = tab_pkg::S_REJECT;
                end else begin
                    n_state = tab_pkg::S_ALIGN_WAIT;
                end
            end
            tab_pkg::S_ALIGN_WAIT: begin
                if (i_sts.mod_done) n_state = tab_pkg::S_ALIGN_SET;
            end
            tab_pkg::S_ALIGN_SET: begin
                n_state = tab_pkg::S_SCAN_RD;
            end
            tab_pkg::S_SCAN_RD: begin
                n_state = i_sts.scan_end ? tab_pkg::S_OPEN : tab_pkg::S_SCAN_CHK;
            end
            tab_pkg::S_SCAN_CHK: begin
                n_state = i_sts.match ? tab_pkg::S_USED_WAIT : tab_pkg::S_SCAN_RD;
            end
            tab_pkg::S_USED_WAIT: begin
                if (i_sts.mod_done) n_state = tab_pkg::S_PAD;
            end
            tab_pkg::S_PAD: begin
                n_state = tab_pkg::S_FIT;
            end
            tab_pkg::S_FIT: begin
                if (!i_sts.fit) begin
                    n_state = tab_pkg::S_SCAN_RD;
                end else if (out_free) begin
                    n_state = tab_pkg::S_IDLE;
                end
            end
            tab_pkg::S_OPEN: begin
                if (i_sts.table_full) begin
                    n_state = tab_pkg::S_FULL;
                end else if (out_free) begin
                    n_state = tab_pkg::S_IDLE;
                end
            end
            tab_pkg::S_FRAME, tab_pkg::S_REJECT, tab_pkg::S_FULL: begin
                if (out_free) n_state = tab_pkg::S_IDLE;
            end
            default: begin
                n_state = tab_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = tab_pkg::RES_TOO_LARGE;
        o_s_ready     = 1'b0;
        case (r_state)
            tab_pkg::S_IDLE: begin
                o_s_ready      = 1'b1;
                o_cmd.load_req = i_s_valid;
            end
            tab_pkg::S_CHECK: begin
                o_cmd.size_ld      = 1'b1;
                o_cmd.mod_go_align = ~i_sts.is_frame & ~i_sts.bad_kind & ~i_sts.oversize;
            end
            tab_pkg::S_ALIGN_SET: begin
                o_cmd.align_set = 1'b1;
                o_cmd.scan_clr  = 1'b1;
            end
            tab_pkg::S_SCAN_RD: begin
                o_cmd.scan_rd = ~i_sts.scan_end;
            end
            tab_pkg::S_SCAN_CHK: begin
                o_cmd.mod_go_used = i_sts.match;
                o_cmd.scan_inc    = ~i_sts.match;
            end
            tab_pkg::S_USED_WAIT: begin
                o_cmd.pad_ld = i_sts.mod_done;
            end
            tab_pkg::S_FIT: begin
                o_cmd.scan_inc = ~i_sts.fit;
                o_cmd.wr_bump  = i_sts.fit & out_free;
                o_cmd.res_ld   = i_sts.fit & out_free;
                o_cmd.res_sel  = tab_pkg::RES_GRANT;
            end
            tab_pkg::S_OPEN: begin
                o_cmd.wr_open = ~i_sts.table_full & out_free;
                o_cmd.res_ld  = ~i_sts.table_full & out_free;
                o_cmd.res_sel = tab_pkg::RES_OPEN;
            end
            tab_pkg::S_FRAME: begin
                o_cmd.frame_clr = out_free;
                o_cmd.res_ld    = out_free;
                o_cmd.res_sel   = tab_pkg::RES_RESET;
            end
            tab_pkg::S_REJECT: begin
                o_cmd.res_ld  = out_free;
                o_cmd.res_sel = tab_pkg::RES_TOO_LARGE;
            end
            tab_pkg::S_FULL: begin
                o_cmd.res_ld  = out_free;
                o_cmd.res_sel = tab_pkg::RES_FULL;
            end
            default: ;
        endcase
    end

    assign o_m_valid = r_out_vld;

endmodule

`default_nettype wire

/* rtl/core/tab_checker.sv */
// ----------------------------------------------------------------------------
// tab_checker
// port-level assertions of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tab_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [tab_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [tab_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // refused results carry no range
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != tab_pkg::STS_GRANTED |->
            m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("refused result with nonzero fields");

    // a new arena grants at offset zero
    a_open_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[27:4] == '0 && m_axis_tuser[2:1] == tab_pkg::STS_GRANTED)
        else $error("opened arena with nonzero offset");

    // a transfer in flight blocks the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    // nothing pending after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind typed_arena_bump_allocator tab_checker u_tab_checker (.*);

`default_nettype wire

/* tb/arena_grant_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arena_grant_checker
// Watches the request, result and register write channels of the typed arena
// bump allocator. It keeps its own copy of the arena table and of the
// registers, works out the grant that each request transfer should produce
// and compares every result transfer, field by field, with the oldest
// outstanding grant.
// ----------------------------------------------------------------------------
module arena_grant_checker
    import tab_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    // request_bytes[23:0], request_align[40:24], zero fill
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // opcode[0], arena_kind_req[2:1]
    input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // arena_slot[3:0], grant_offset[27:4], grant_bytes[51:28], zero fill
    input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,
    // opened_arena[0], status[2:1]
    input  wire logic [M_TUSER_W-1:0]  m_axis_tuser,
    output int                         o_pending,
    output int                         o_errors
);

    localparam int     ARENAS   = DEF_MAX_ARENAS;
    localparam longint SIZE_CAP = (longint'(1) << DEF_SIZE_BITS) - 1;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [BYTES_W-1:0] offset;
        logic [BYTES_W-1:0] bytes;
        logic               opened;
        logic [1:0]         status;
    } grant_t;

    logic [1:0]         tag_r  [ARENAS];
    logic [BYTES_W-1:0] used_r [ARENAS];
    int                 open_cnt;

    logic [BYTES_W-1:0] vtx_size;
    logic [BYTES_W-1:0] idx_size;
    logic [USZ_W-1:0]   uni_size;
    logic [UAL_W-1:0]   uni_align;

    grant_t grant_q [$];
    grant_t want;
    int     mismatch_cnt = 0;

    function automatic grant_t allocate_range(input logic opc, input logic [1:0] kind,
                                              input logic [BYTES_W-1:0] req_bytes,
                                              input logic [ALIGN_W-1:0] req_align);
        grant_t g;
        longint size;
        longint base;
        longint algn;
        longint used;
        longint pad;
        int     n;
        g = '0;
        if (opc == OP_FRAME_RESET) begin
            for (int i = 0; i < ARENAS; i++) used_r[i] = '0;
            g.status = STS_RESET_DONE;
            return g;
        end
        if (kind == KIND_NONE) begin
            g.status = STS_TOO_LARGE;
            return g;
        end
        case (kind)
            KIND_VERTEX: begin
                size = vtx_size;
                base = VERTEX_BASE_ALIGN;
            end
            KIND_INDEX: begin
                size = idx_size;
                base = INDEX_BASE_ALIGN;
            end
            default: begin
                size = (uni_size > UNIFORM_CLAMP) ? UNIFORM_CLAMP : uni_size;
                base = (uni_align == '0) ? 1 : uni_align;
            end
        endcase
        if (size > SIZE_CAP) size = SIZE_CAP;
        if (req_bytes > size) begin
            g.status = STS_TOO_LARGE;
            return g;
        end
        algn = req_align;
        if (algn == 0 || (algn % base) != 0) algn = base;

        n = (open_cnt > ARENAS) ? ARENAS : open_cnt;
        for (int i = 0; i < n; i++) begin
            // an arena holding more than the current size counts as full
            if (tag_r[i] == kind && used_r[i] <= size) begin
                used = used_r[i];
                pad  = (algn - used % algn) % algn;
                if (size - used >= req_bytes + pad) begin
                    used_r[i] = BYTES_W'(used + pad + req_bytes);
                    g.slot    = SLOT_W'(i);
                    g.offset  = BYTES_W'(used + pad);
                    g.bytes   = req_bytes;
                    g.status  = STS_GRANTED;
                    return g;
                end
            end
        end

        if (n >= ARENAS) begin
            g.status = STS_TABLE_FULL;
            return g;
        end
        tag_r[n]  = kind;
        used_r[n] = req_bytes;
        open_cnt  = n + 1;
        g.slot    = SLOT_W'(n);
        g.bytes   = req_bytes;
        g.opened  = 1'b1;
        g.status  = STS_GRANTED;
        return g;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ARENAS; i++) begin
                tag_r[i]  = (i < RST_ARENAS) ? 2'(i) : 2'd0;
                used_r[i] = '0;
            end
            open_cnt  = RST_ARENAS;
            vtx_size  = RST_VTX_SIZE;
            idx_size  = RST_IDX_SIZE;
            uni_size  = RST_UNI_SIZE;
            uni_align = RST_UNI_ALIGN;
            grant_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VTX_SIZE:  vtx_size  = i_cfg_data[BYTES_W-1:0];
                    CFG_IDX_SIZE:  idx_size  = i_cfg_data[BYTES_W-1:0];
                    CFG_UNI_SIZE:  uni_size  = i_cfg_data[USZ_W-1:0];
                    CFG_UNI_ALIGN: uni_align = i_cfg_data[UAL_W-1:0];
                    default: ;
                endcase
            end
            // results first: a result never belongs to a request taken on the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (grant_q.size() == 0) begin
                    $error("result transfer with no grant outstanding");
                    mismatch_cnt++;
                end else begin
                    want = grant_q.pop_front();
                    check_field("arena_slot", want.slot, m_axis_tdata[3:0]);
                    check_field("grant_offset", want.offset, m_axis_tdata[27:4]);
                    check_field("grant_bytes", want.bytes, m_axis_tdata[51:28]);
                    check_field("opened_arena", want.opened, m_axis_tuser[0]);
                    check_field("status", want.status, m_axis_tuser[2:1]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                grant_q.push_back(allocate_range(s_axis_tuser[0], s_axis_tuser[2:1],
                                                 s_axis_tdata[23:0], s_axis_tdata[40:24]));
            end
        end
        o_pending <= grant_q.size();
        o_errors  <= mismatch_cnt;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the typed arena bump allocator. A directed run
// covers the field extremes, alignment fallback, oversize and unknown kinds,
// shrunk arenas and frame resets; then several register settings, extremes
// among them, each carry a burst of random requests, mostly with random gaps
// on both streams. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module testbench;
    import tab_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    int pending;
    int errors;
    bit idle_en = 1'b1;

    // register values last written, used only to shape request sizes and alignments
    int unsigned vtx_lim = RST_VTX_SIZE;
    int unsigned idx_lim = RST_IDX_SIZE;
    int unsigned uni_lim = RST_UNI_SIZE;
    int unsigned uni_al  = RST_UNI_ALIGN;

    typed_arena_bump_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    arena_grant_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic int rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 3) == 0) begin
                stall = rand_gap() + 1;
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_req(input logic opc, input logic [1:0] kind,
                            input logic [BYTES_W-1:0] req_bytes,
                            input logic [ALIGN_W-1:0] req_align);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({req_align, req_bytes});
        s_axis_tuser  <= {kind, opc};
        do @(posedge i_clk); while (!s_axis_tready);
        gap = idle_en ? rand_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] v, input logic [CFG_W-1:0] x,
                             input logic [CFG_W-1:0] u, input logic [CFG_W-1:0] a);
        drain();
        write_cfg(CFG_VTX_SIZE, v);
        write_cfg(CFG_IDX_SIZE, x);
        write_cfg(CFG_UNI_SIZE, u);
        write_cfg(CFG_UNI_ALIGN, a);
        i_cfg_we <= 1'b0;
        vtx_lim = v;
        idx_lim = x;
        uni_lim = (u[USZ_W-1:0] > UNIFORM_CLAMP) ? UNIFORM_CLAMP : u[USZ_W-1:0];
        uni_al  = (a[UAL_W-1:0] == '0) ? 1 : a[UAL_W-1:0];
    endtask

    function automatic logic [CFG_W-1:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return CFG_W'($urandom_range(1, 4096));
        if (r < 90) return CFG_W'($urandom_range(4097, 65536));
        return CFG_W'($urandom_range(1, 24'hFFFFFF));
    endfunction

    function automatic logic [CFG_W-1:0] rand_align_reg();
        logic [CFG_W-1:0] a;
        int unsigned      r;
        r = $urandom_range(0, 9);
        if (r < 7) a = CFG_W'(1 << $urandom_range(0, 8));
        else if (r < 8) a = '0;
        else a = CFG_W'($urandom_range(0, 511));
        // bits above the register width are ignored by the block
        return a | (CFG_W'($urandom) & 24'hFFFE00);
    endfunction

    function automatic logic [1:0] pick_kind();
        if ($urandom_range(0, 99) < 5) return KIND_NONE;
        return 2'($urandom_range(0, 2));
    endfunction

    function automatic logic [BYTES_W-1:0] pick_bytes(input logic [1:0] kind);
        int unsigned lim;
        int unsigned r;
        case (kind)
            KIND_VERTEX:  lim = vtx_lim;
            KIND_INDEX:   lim = idx_lim;
            KIND_UNIFORM: lim = uni_lim;
            default:      lim = 4096;
        endcase
        r = $urandom_range(0, 99);
        if (r < 6) return BYTES_W'($urandom);
        if (r < 12) return (lim >= 24'hFFFFF0) ? 24'hFFFFFF : BYTES_W'(lim + $urandom_range(1, 16));
        if (r < 20) return BYTES_W'(lim);
        return BYTES_W'($urandom_range(0, lim / 4));
    endfunction

    function automatic logic [ALIGN_W-1:0] pick_align(input logic [1:0] kind);
        int unsigned r;
        int unsigned base;
        case (kind)
            KIND_VERTEX:  base = VERTEX_BASE_ALIGN;
            KIND_INDEX:   base = INDEX_BASE_ALIGN;
            default:      base = uni_al;
        endcase
        r = $urandom_range(0, 99);
        if (r < 25) return '0;
        if (r < 55) return ALIGN_W'(1 << $urandom_range(0, 16));
        if (r < 80) return ALIGN_W'(base * $urandom_range(1, 8));
        return ALIGN_W'($urandom_range(0, 17'h1FFFF));
    endfunction

    initial begin
        logic [1:0] kind;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_VTX_SIZE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        send_req(OP_FRAME_RESET, KIND_VERTEX, '0, '0);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd0, 17'd0);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd3, 17'd0);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd5, 17'd3);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd100, 17'd65536);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd1, 17'h1FFFF);
        send_req(OP_ACQUIRE, KIND_INDEX, 24'd65536, 17'd2);
        send_req(OP_ACQUIRE, KIND_INDEX, 24'd65537, 17'd0);
        send_req(OP_ACQUIRE, KIND_INDEX, 24'd1, 17'd0);
        send_req(OP_ACQUIRE, KIND_UNIFORM, 24'd256, 17'd0);
        send_req(OP_ACQUIRE, KIND_UNIFORM, 24'd1, 17'd512);
        send_req(OP_ACQUIRE, KIND_NONE, 24'd5, 17'd0);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'hFFFFFF, 17'd0);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd262144, 17'd0);

        // shrunk arenas, uniform size above the clamp, zero uniform alignment
        configure(24'd16, 24'd1, 24'h01FFFF, 24'hFFFE00);
        send_req(OP_ACQUIRE, KIND_INDEX, 24'd1, 17'd0);
        send_req(OP_ACQUIRE, KIND_UNIFORM, 24'd65536, 17'd0);
        send_req(OP_ACQUIRE, KIND_UNIFORM, 24'd65537, 17'd0);
        send_req(OP_ACQUIRE, KIND_UNIFORM, 24'd3, 17'd7);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd16, 17'd0);
        send_req(OP_ACQUIRE, KIND_VERTEX, 24'd0, 17'd0);
        send_req(OP_FRAME_RESET, KIND_NONE, 24'hFFFFFF, 17'h1FFFF);
        send_req(OP_ACQUIRE, KIND_INDEX, 24'd1, 17'd0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0001FF);
                1: configure(24'd1, 24'd1, 24'd1, 24'd1);
                2: configure(rand_size(), rand_size(), 24'd65536, 24'd256);
                default: configure(rand_size(), rand_size(),
                                   rand_size() ^ (CFG_W'($urandom) & 24'hFE0000),
                                   rand_align_reg());
            endcase
            idle_en = (ph % 3) != 2;
            for (int n = 0; n < 180; n++) begin
                if ($urandom_range(0, 99) < 4) begin
                    send_req(OP_FRAME_RESET, 2'($urandom), BYTES_W'($urandom),
                             ALIGN_W'($urandom));
                end else begin
                    kind = pick_kind();
                    send_req(OP_ACQUIRE, kind, pick_bytes(kind), pick_align(kind));
                end
            end
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
